// ----- src/blt_pkg.sv -----
// Shared types and constants for the line tokenizer.
// Used by blt_lexer, blt_outq and basic_line_tokenizer; no dependencies.
package blt_pkg;

  localparam int MAX_TOKEN_LEN = 64;
  localparam int NUMBER_WIDTH  = 32;
  localparam int LEN_W         = $clog2(MAX_TOKEN_LEN);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;

  typedef enum logic [2:0] {
    KIND_NUM = 3'd0,
    KIND_STR = 3'd1,
    KIND_SYM = 3'd2,
    KIND_ID  = 3'd3,
    KIND_ERR = 3'd4,
    KIND_EOL = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_UNTERM   = 3'd1,
    ERR_ESCAPE   = 3'd2,
    ERR_BAD_BYTE = 3'd3,
    ERR_TOO_LONG = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_NUM   = 3'd1,
    MODE_MINUS = 3'd2,
    MODE_CMP   = 3'd3,
    MODE_STR   = 3'd4,
    MODE_ESC   = 3'd5,
    MODE_ID    = 3'd6,
    MODE_SKIP  = 3'd7
  } mode_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  text_char;
    logic        has_char;
    logic [31:0] value;
    logic        token_end;
    err_t        error_code;
    logic        last;
  } result_t;

  // Results produced by one accepted byte: slot 0 first, cnt in 0..2.
  typedef struct packed {
    result_t    r1;
    result_t    r0;
    logic [1:0] cnt;
  } push_t;

  function automatic result_t mk_result(kind_t k, logic [7:0] c, logic has,
                                        logic [31:0] v, logic e, err_t err);
    result_t r;
    r.kind       = k;
    r.text_char  = c;
    r.has_char   = has;
    r.value      = v;
    r.token_end  = e;
    r.error_code = err;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

// ----- src/blt_lexer.sv -----
// Lexer state and per-byte token logic for the line tokenizer.
// Depends on blt_pkg.
module blt_lexer (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    ch,
  output blt_pkg::push_t push
);

  blt_pkg::mode_t                    mode, mode_next;
  logic [7:0]                        pending_char, pending_char_next;
  logic [blt_pkg::NUMBER_WIDTH-1:0]  number_accum, number_accum_next;
  logic                              number_negative, number_negative_next;
  logic [blt_pkg::LEN_W-1:0]         token_length, token_length_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= blt_pkg::MODE_IDLE;
      pending_char    <= '0;
      number_accum    <= '0;
      number_negative <= 1'b0;
      token_length    <= '0;
    end else if (accept) begin
      mode            <= mode_next;
      pending_char    <= pending_char_next;
      number_accum    <= number_accum_next;
      number_negative <= number_negative_next;
      token_length    <= token_length_next;
    end
  end

  logic is_digit, is_letter, is_word, is_space;
  logic [blt_pkg::NUMBER_WIDTH-1:0] digit_val, num_signed;
  logic [31:0] num_value;

  assign is_digit  = (ch >= blt_pkg::CH_ZERO) && (ch <= blt_pkg::CH_NINE);
  assign is_letter = ((ch >= blt_pkg::CH_LC_A) && (ch <= blt_pkg::CH_LC_Z)) ||
                     ((ch >= blt_pkg::CH_UC_A) && (ch <= blt_pkg::CH_UC_Z));
  assign is_word   = is_letter || is_digit || (ch == blt_pkg::CH_USCORE);
  assign is_space  = (ch == blt_pkg::CH_SPACE) || (ch == blt_pkg::CH_TAB);
  assign digit_val = blt_pkg::NUMBER_WIDTH'(ch[3:0]);
  assign num_signed = number_negative ? (~number_accum + 1'b1) : number_accum;
  assign num_value  = 32'($signed(num_signed));

  blt_pkg::result_t res [2];
  logic [1:0]       n;
  logic             do_idle;
  logic             esc_ok;
  logic [7:0]       esc_char;
  logic             app_en;
  blt_pkg::kind_t   app_kind;
  logic [7:0]       app_char;

  always_comb begin
    mode_next            = mode;
    pending_char_next    = pending_char;
    number_accum_next    = number_accum;
    number_negative_next = number_negative;
    token_length_next    = token_length;
    res[0]   = blt_pkg::mk_result(blt_pkg::KIND_NUM, '0, 1'b0, '0, 1'b0, blt_pkg::ERR_NONE);
    res[1]   = res[0];
    n        = 2'd0;
    do_idle  = 1'b0;
    app_en   = 1'b0;
    app_kind = blt_pkg::KIND_STR;
    app_char = ch;
    esc_ok   = 1'b1;
    esc_char = ch;

    unique case (ch)
      blt_pkg::CH_QUOTE:  esc_char = blt_pkg::CH_QUOTE;
      blt_pkg::CH_BSLASH: esc_char = blt_pkg::CH_BSLASH;
      blt_pkg::CH_LC_N:   esc_char = blt_pkg::CH_NL;
      blt_pkg::CH_LC_T:   esc_char = blt_pkg::CH_TAB;
      default:            esc_ok   = 1'b0;
    endcase

    unique case (mode)
      blt_pkg::MODE_NUM: begin
        if (is_digit) begin
          number_accum_next = (number_accum << 3) + (number_accum << 1) + digit_val;
        end else begin
          res[0]  = blt_pkg::mk_result(blt_pkg::KIND_NUM, '0, 1'b0, num_value, 1'b1,
                                       blt_pkg::ERR_NONE);
          n       = 2'd1;
          do_idle = 1'b1;
        end
      end
      blt_pkg::MODE_MINUS: begin
        if (is_digit) begin
          mode_next            = blt_pkg::MODE_NUM;
          number_accum_next    = digit_val;
          number_negative_next = 1'b1;
        end else begin
          res[0]  = blt_pkg::mk_result(blt_pkg::KIND_SYM, blt_pkg::CH_MINUS, 1'b1, '0, 1'b1,
                                       blt_pkg::ERR_NONE);
          n       = 2'd1;
          do_idle = 1'b1;
        end
      end
      blt_pkg::MODE_CMP: begin
        if (ch == blt_pkg::CH_EQ) begin
          res[0]    = blt_pkg::mk_result(blt_pkg::KIND_SYM, pending_char, 1'b1, '0, 1'b0,
                                         blt_pkg::ERR_NONE);
          res[1]    = blt_pkg::mk_result(blt_pkg::KIND_SYM, blt_pkg::CH_EQ, 1'b1, '0, 1'b1,
                                         blt_pkg::ERR_NONE);
          n         = 2'd2;
          mode_next = blt_pkg::MODE_IDLE;
        end else begin
          res[0]  = blt_pkg::mk_result(blt_pkg::KIND_SYM, pending_char, 1'b1, '0, 1'b1,
                                       blt_pkg::ERR_NONE);
          n       = 2'd1;
          do_idle = 1'b1;
        end
      end
      blt_pkg::MODE_STR: begin
        priority if (ch == blt_pkg::CH_NUL) begin
          res[0]    = blt_pkg::mk_result(blt_pkg::KIND_ERR, '0, 1'b0, '0, 1'b1,
                                         blt_pkg::ERR_UNTERM);
          res[1]    = blt_pkg::mk_result(blt_pkg::KIND_EOL, '0, 1'b0, '0, 1'b0,
                                         blt_pkg::ERR_NONE);
          n         = 2'd2;
          mode_next = blt_pkg::MODE_IDLE;
        end else if (ch == blt_pkg::CH_QUOTE) begin
          res[0]    = blt_pkg::mk_result(blt_pkg::KIND_STR, '0, 1'b0, '0, 1'b1,
                                         blt_pkg::ERR_NONE);
          n         = 2'd1;
          mode_next = blt_pkg::MODE_IDLE;
        end else if (ch == blt_pkg::CH_BSLASH) begin
          mode_next = blt_pkg::MODE_ESC;
        end else begin
          app_en = 1'b1;
        end
      end
      blt_pkg::MODE_ESC: begin
        if (esc_ok) begin
          mode_next = blt_pkg::MODE_STR;
          app_en    = 1'b1;
          app_char  = esc_char;
        end else begin
          res[0]    = blt_pkg::mk_result(blt_pkg::KIND_ERR, '0, 1'b0, '0, 1'b1,
                                         blt_pkg::ERR_ESCAPE);
          n         = 2'd1;
          mode_next = blt_pkg::MODE_SKIP;
          if (ch == blt_pkg::CH_NUL) begin
            res[1]    = blt_pkg::mk_result(blt_pkg::KIND_EOL, '0, 1'b0, '0, 1'b0,
                                           blt_pkg::ERR_NONE);
            n         = 2'd2;
            mode_next = blt_pkg::MODE_IDLE;
          end
        end
      end
      blt_pkg::MODE_ID: begin
        if (is_word) begin
          app_en   = 1'b1;
          app_kind = blt_pkg::KIND_ID;
        end else begin
          res[0]  = blt_pkg::mk_result(blt_pkg::KIND_ID, '0, 1'b0, '0, 1'b1,
                                       blt_pkg::ERR_NONE);
          n       = 2'd1;
          do_idle = 1'b1;
        end
      end
      blt_pkg::MODE_SKIP: begin
        if (ch == blt_pkg::CH_NUL) begin
          res[0]    = blt_pkg::mk_result(blt_pkg::KIND_EOL, '0, 1'b0, '0, 1'b0,
                                         blt_pkg::ERR_NONE);
          n         = 2'd1;
          mode_next = blt_pkg::MODE_IDLE;
        end
      end
      blt_pkg::MODE_IDLE: begin
        do_idle = 1'b1;
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    // Append with the length check; nothing else has been emitted in this case.
    if (app_en) begin
      if (token_length >= blt_pkg::LEN_W'(blt_pkg::MAX_TOKEN_LEN - 1)) begin
        res[0]    = blt_pkg::mk_result(blt_pkg::KIND_ERR, '0, 1'b0, '0, 1'b1,
                                       blt_pkg::ERR_TOO_LONG);
        mode_next = blt_pkg::MODE_SKIP;
      end else begin
        res[0]            = blt_pkg::mk_result(app_kind, app_char, 1'b1, '0, 1'b0,
                                               blt_pkg::ERR_NONE);
        token_length_next = token_length + 1'b1;
      end
      n = 2'd1;
    end

    // Byte handled as if between tokens; at most one result lands after slot n.
    if (do_idle) begin
      mode_next = blt_pkg::MODE_IDLE;
      priority if (is_space) begin
        mode_next = blt_pkg::MODE_IDLE;
      end else if (ch == blt_pkg::CH_NUL) begin
        res[n[0]] = blt_pkg::mk_result(blt_pkg::KIND_EOL, '0, 1'b0, '0, 1'b0,
                                       blt_pkg::ERR_NONE);
        n = n + 2'd1;
      end else if (is_digit) begin
        mode_next            = blt_pkg::MODE_NUM;
        number_accum_next    = digit_val;
        number_negative_next = 1'b0;
      end else if (ch == blt_pkg::CH_MINUS) begin
        mode_next = blt_pkg::MODE_MINUS;
      end else if ((ch == blt_pkg::CH_LPAREN) || (ch == blt_pkg::CH_RPAREN) ||
                   (ch == blt_pkg::CH_COMMA) || (ch == blt_pkg::CH_PLUS) ||
                   (ch == blt_pkg::CH_STAR) || (ch == blt_pkg::CH_SLASH)) begin
        res[n[0]] = blt_pkg::mk_result(blt_pkg::KIND_SYM, ch, 1'b1, '0, 1'b1,
                                       blt_pkg::ERR_NONE);
        n = n + 2'd1;
      end else if ((ch == blt_pkg::CH_LT) || (ch == blt_pkg::CH_GT) ||
                   (ch == blt_pkg::CH_EQ) || (ch == blt_pkg::CH_BANG)) begin
        pending_char_next = ch;
        mode_next         = blt_pkg::MODE_CMP;
      end else if (ch == blt_pkg::CH_QUOTE) begin
        token_length_next = '0;
        mode_next         = blt_pkg::MODE_STR;
      end else if (is_letter || (ch == blt_pkg::CH_USCORE)) begin
        token_length_next = blt_pkg::LEN_W'(1);
        mode_next         = blt_pkg::MODE_ID;
        res[n[0]] = blt_pkg::mk_result(blt_pkg::KIND_ID, ch, 1'b1, '0, 1'b0,
                                       blt_pkg::ERR_NONE);
        n = n + 2'd1;
      end else begin
        res[n[0]] = blt_pkg::mk_result(blt_pkg::KIND_ERR, '0, 1'b0, '0, 1'b1,
                                       blt_pkg::ERR_BAD_BYTE);
        n = n + 2'd1;
        mode_next = blt_pkg::MODE_SKIP;
      end
    end

    if (n == 2'd1) begin
      res[0].last = 1'b1;
    end else if (n == 2'd2) begin
      res[1].last = 1'b1;
    end

    push.r0  = res[0];
    push.r1  = res[1];
    push.cnt = n;
  end

endmodule

// ----- src/blt_outq.sv -----
// Three-entry result queue: takes up to two results per cycle, gives one.
// Depends on blt_pkg.
module blt_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_en,
  input  blt_pkg::push_t    push,
  input  logic              pop,
  output logic              not_empty,
  output logic              full_ish,
  output blt_pkg::result_t  head
);

  blt_pkg::result_t entries [3];
  logic [1:0] rd_ptr, wr_ptr, count;
  logic [1:0] wr_ptr_p1, push_cnt;

  function automatic logic [1:0] inc3(logic [1:0] p);
    return (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  assign push_cnt  = push_en ? push.cnt : 2'd0;
  assign wr_ptr_p1 = inc3(wr_ptr);
  assign not_empty = (count != 2'd0);
  // Room for two more is only guaranteed with at most one entry held.
  assign full_ish  = (count > 2'd1);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (pop) begin
        rd_ptr <= inc3(rd_ptr);
      end
      unique case (push_cnt)
        2'd1:    wr_ptr <= wr_ptr_p1;
        2'd2:    wr_ptr <= inc3(wr_ptr_p1);
        default: wr_ptr <= wr_ptr;
      endcase
      count <= count + push_cnt - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push_cnt == 2'd2) begin
      entries[wr_ptr_p1] <= push.r1;
    end
  end

endmodule

// ----- src/basic_line_tokenizer.sv -----
// Line tokenizer: one text byte per transfer in, token results out.
// Each result is written into the result queue before it is presented at the output.
// One byte per cycle while each byte yields at most one result and out_stall is low;
// a byte yielding two results can raise in_stall, since the queue holds three entries.
// Reset (rst, synchronous) returns the lexer to between-tokens and empties the queue.
// Depends on blt_pkg, blt_lexer and blt_outq.
module basic_line_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  ch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [7:0]  text_char,
  output logic        has_char,
  output logic [31:0] value,
  output logic        token_end,
  output logic [2:0]  error_code,
  output logic        last
);

  logic             accept, pop, full_ish;
  blt_pkg::push_t   push;
  blt_pkg::result_t head;

  assign accept = in_valid && !in_stall;
  assign pop    = out_valid && !out_stall;
  assign in_stall = full_ish;

  blt_lexer u_lexer (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .ch     (ch),
    .push   (push)
  );

  blt_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push_en   (accept),
    .push      (push),
    .pop       (pop),
    .not_empty (out_valid),
    .full_ish  (full_ish),
    .head      (head)
  );

  assign kind       = head.kind;
  assign text_char  = head.text_char;
  assign has_char   = head.has_char;
  assign value      = head.value;
  assign token_end  = head.token_end;
  assign error_code = head.error_code;
  assign last       = head.last;

endmodule
